// File: hw/rtl/lk2_pkg.sv
// ----------------------------------------------------------------------------
// lk2_pkg
// Shared types, constants and the single mix step of the lookup2 hash.
// ----------------------------------------------------------------------------
package lk2_pkg;

	localparam int BLOCK_LEN = 12;
	localparam int FILL_W    = 4;
	localparam int MIX_STEPS = 9;

	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	typedef logic [31:0] word_t;

	// which of a, b, c a mix step rewrites
	typedef enum logic [1:0] {
		MIX_A,
		MIX_B,
		MIX_C
	} mix_target_t;

	localparam int unsigned MIX_SHIFT [MIX_STEPS] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};
	localparam mix_target_t MIX_TARGET [MIX_STEPS] = '{
		MIX_A, MIX_B, MIX_C,
		MIX_A, MIX_B, MIX_C,
		MIX_A, MIX_B, MIX_C
	};

	typedef struct packed {
		logic  valid;
		logic  is_final;
		word_t a;
		word_t b;
		word_t c;
	} mix_entry_t;

	function automatic mix_entry_t mix_step(input int unsigned k, input mix_entry_t e);
		mix_entry_t r;
		r = e;
		unique case (MIX_TARGET[k])
			MIX_A:   r.a = (e.a - e.b - e.c) ^ (e.c >> MIX_SHIFT[k]);
			MIX_B:   r.b = (e.b - e.c - e.a) ^ (e.a << MIX_SHIFT[k]);
			MIX_C:   r.c = (e.c - e.a - e.b) ^ (e.b >> MIX_SHIFT[k]);
			default: r = e;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/lookup2_byte_hash.sv
// ----------------------------------------------------------------------------
// lookup2_byte_hash
// Streaming 32-bit lookup2 hash over a byte stream, at most one byte per transaction.
// ----------------------------------------------------------------------------
// One byte is taken per cycle into an input register; bytes collect into a
// 12-byte block while a ten-stage mix pipeline (launch register plus one
// register per mix step) works on the previous block, so a long message
// streams at one byte per clock. The hash of a message is formed in the
// launch and mix registers and then held in the result register. A closing
// transaction that arrives while the last block of its message is still in
// the mix pipeline, or whose own byte completes a block, is held in the input
// register until that block has left the pipeline. The pipeline and the
// input stage stop while a finished hash waits at the output.
module lookup2_byte_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);
	import lk2_pkg::*;

	logic              s1_valid_q;
	logic [7:0]        s1_byte_q;
	logic              s1_present_q;
	logic              s1_last_q;

	word_t             acc_a_q;
	word_t             acc_b_q;
	word_t             acc_c_q;
	logic [7:0]        buf_q [BLOCK_LEN];
	logic [FILL_W-1:0] fill_q;
	word_t             len_q;
	logic              busy_q;

	logic              out_valid_q;
	word_t             hash_q;

	logic              adv;
	logic              proc;
	logic              complete;
	logic              hold_close;
	logic              s1_done;
	logic              close_msg;
	logic [7:0]        eff [BLOCK_LEN];
	word_t             w0;
	word_t             w1;
	word_t             w2;
	word_t             len_next;
	mix_entry_t        launch;
	mix_entry_t        tail;
	logic              wb;

	assign adv        = !out_valid_q || out_ready;
	// a close has to wait for the block mix of its own message
	assign proc       = adv && s1_valid_q && !(s1_last_q && busy_q);
	assign complete   = s1_present_q && (fill_q == FILL_W'(BLOCK_LEN - 1));
	assign hold_close = complete && s1_last_q;
	assign s1_done    = proc && !hold_close;
	assign close_msg  = proc && s1_last_q && !complete;
	assign in_ready   = !s1_valid_q || s1_done;
	assign len_next   = len_q + 32'(s1_present_q);

	// block view with the incoming byte merged in; unfilled places read as zero
	always_comb begin
		for (int p = 0; p < BLOCK_LEN; p++) begin
			if (FILL_W'(p) < fill_q) begin
				eff[p] = buf_q[p];
			end else if (s1_present_q && (FILL_W'(p) == fill_q)) begin
				eff[p] = s1_byte_q;
			end else begin
				eff[p] = 8'h00;
			end
		end
	end

	assign w0 = {eff[3], eff[2], eff[1], eff[0]};
	assign w1 = {eff[7], eff[6], eff[5], eff[4]};
	assign w2 = {eff[11], eff[10], eff[9], eff[8]};

	always_comb begin
		launch.valid    = proc && (complete || s1_last_q);
		launch.is_final = !complete;
		launch.a        = acc_a_q + w0;
		launch.b        = acc_b_q + w1;
		if (complete) begin
			launch.c = acc_c_q + w2;
		end else begin
			launch.c = acc_c_q + len_next + {w2[23:0], 8'h00};
		end
	end

	lk2_mix_pipe u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.launch (launch),
		.tail   (tail)
	);

	assign wb = adv && tail.valid && !tail.is_final;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_byte_q    <= data_byte;
			s1_present_q <= byte_present;
			s1_last_q    <= last;
		end else if (proc && hold_close) begin
			// byte went out with its block, the close stays behind
			s1_present_q <= 1'b0;
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= GOLDEN;
			acc_b_q <= GOLDEN;
			acc_c_q <= '0;
			fill_q  <= '0;
			len_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (close_msg) begin
				acc_a_q <= GOLDEN;
				acc_b_q <= GOLDEN;
				acc_c_q <= '0;
			end else if (wb) begin
				acc_a_q <= tail.a;
				acc_b_q <= tail.b;
				acc_c_q <= tail.c;
			end
			if (proc) begin
				if (complete || s1_last_q) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + FILL_W'(s1_present_q);
				end
				if (close_msg) begin
					len_q <= '0;
				end else begin
					len_q <= len_next;
				end
			end
			if (proc && complete) begin
				busy_q <= 1'b1;
			end else if (wb) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && s1_present_q) begin
			buf_q[fill_q] <= s1_byte_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tail.valid && tail.is_final;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hash_q <= tail.c;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// File: hw/rtl/lk2_mix_pipe.sv
// ----------------------------------------------------------------------------
// lk2_mix_pipe
// Pipelined lookup2 mix: one register after each of the nine mix steps.
// ----------------------------------------------------------------------------
module lk2_mix_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lk2_pkg::mix_entry_t launch,
	output lk2_pkg::mix_entry_t tail
);
	import lk2_pkg::*;

	mix_entry_t stg_q    [MIX_STEPS+1];
	mix_entry_t stg_next [MIX_STEPS+1];
	logic [MIX_STEPS:0] vld_q;

	always_comb begin
		stg_next[0] = launch;
		for (int k = 0; k < MIX_STEPS; k++) begin
			stg_next[k+1] = mix_step(k, stg_q[k]);
		end
	end

	// valid bits move with the data but only through reset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[MIX_STEPS-1:0], launch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_q <= stg_next;
		end
	end

	always_comb begin
		tail       = stg_q[MIX_STEPS];
		tail.valid = vld_q[MIX_STEPS];
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lookup2_byte_hash: byte messages are streamed in
// with random gaps and output stalls, a behavioral copy of the lookup2 hash
// predicts each closing hash, and every returned hash is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import lk2_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] hash_value;

	lookup2_byte_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predicted message state
	logic [31:0] hash_a;
	logic [31:0] hash_b;
	logic [31:0] hash_c;
	logic [7:0]  blk [BLOCK_LEN];
	int          blk_fill;
	logic [31:0] msg_len;

	logic [31:0] expected_hash [$];
	logic [31:0] hash_want;
	int          mismatches;
	int          items_sent;
	bit          steady;      // no idling on either side
	int          hold_cycles; // long receiver hold-off request

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic mix_abc(inout logic [31:0] a, inout logic [31:0] b, inout logic [31:0] c);
		a = (a - b - c) ^ (c >> 13);
		b = (b - c - a) ^ (a << 8);
		c = (c - a - b) ^ (b >> 13);
		a = (a - b - c) ^ (c >> 12);
		b = (b - c - a) ^ (a << 16);
		c = (c - a - b) ^ (b >> 5);
		a = (a - b - c) ^ (c >> 3);
		b = (b - c - a) ^ (a << 10);
		c = (c - a - b) ^ (b >> 15);
	endtask

	function automatic void hash_clear();
		hash_a   = GOLDEN;
		hash_b   = GOLDEN;
		hash_c   = 32'd0;
		blk_fill = 0;
		msg_len  = 32'd0;
	endfunction

	// update the prediction with one accepted transaction
	task automatic hash_absorb(input logic [7:0] b, input logic p, input logic l);
		logic [31:0] v;
		int          i;
		if (p) begin
			blk[blk_fill] = b;
			blk_fill++;
			msg_len = msg_len + 32'd1;
			if (blk_fill == BLOCK_LEN) begin
				hash_a = hash_a + {blk[3], blk[2], blk[1], blk[0]};
				hash_b = hash_b + {blk[7], blk[6], blk[5], blk[4]};
				hash_c = hash_c + {blk[11], blk[10], blk[9], blk[8]};
				mix_abc(hash_a, hash_b, hash_c);
				blk_fill = 0;
			end
		end
		if (l) begin
			hash_c = hash_c + msg_len;
			for (i = 0; i < blk_fill; i++) begin
				v = {24'd0, blk[i]};
				if (i < 4)
					hash_a = hash_a + (v << (8 * i));
				else if (i < 8)
					hash_b = hash_b + (v << (8 * (i - 4)));
				else
					hash_c = hash_c + (v << (8 * (i - 7)));
			end
			mix_abc(hash_a, hash_b, hash_c);
			expected_hash.push_back(hash_c);
			hash_clear();
		end
	endtask

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_byte(input logic [7:0] b, input logic p, input logic l);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		byte_present <= p;
		last         <= l;
		do @(posedge clk); while (!in_ready);
		hash_absorb(b, p, l);
		if (p || l)
			items_sent++;
	endtask

	task automatic send_message(input int len, input bit close_empty, input int noise_pct);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !close_empty);
		end
		if (close_empty || len == 0)
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic test_empty_messages();
		send_byte(8'hff, 1'b0, 1'b1);
		// an empty item that is not last changes nothing
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_tail_lengths();
		int i;
		// longest tail: bytes 8..10 land in c shifted up
		for (i = 0; i < BLOCK_LEN - 1; i++)
			send_byte(8'hff, 1'b1, i == BLOCK_LEN - 2);
		// last byte completes a block, so the tail is empty
		for (i = 0; i < BLOCK_LEN; i++)
			send_byte((i % 2) ? 8'hff : 8'h00, 1'b1, i == BLOCK_LEN - 1);
	endtask

	task automatic test_output_backpressure();
		int i;
		steady      = 1'b1;
		hold_cycles = 80;
		for (i = 0; i < 8; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		send_message(30, 1'b0, 0);
		steady = 1'b0;
	endtask

	task automatic test_random_messages();
		int len;
		int r;
		while (items_sent < 1850) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = $urandom_range(0, 2);
			else if (r < 80)
				len = $urandom_range(1, 26);
			else if (r < 95)
				len = $urandom_range(27, 48);
			else
				len = $urandom_range(49, 100);
			steady = ($urandom_range(0, 7) == 0);
			send_message(len, $urandom_range(0, 4) == 0, $urandom_range(0, 1) ? 5 : 0);
		end
		steady = 1'b0;
	endtask

	// result receiver with random stalls and a long hold-off when one is requested
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 3);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && hold_cycles == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hash.size() == 0) begin
				report_mismatch($sformatf("hash %h with nothing expected", hash_value));
			end else begin
				hash_want = expected_hash.pop_front();
				if (hash_value !== hash_want)
					report_mismatch($sformatf("hash_value %h, want %h", hash_value, hash_want));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("** lookup2_byte_hash: FAILED **");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = 8'd0;
		byte_present = 1'b0;
		last         = 1'b0;
		mismatches   = 0;
		items_sent   = 0;
		steady       = 1'b0;
		hold_cycles  = 0;
		hash_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_messages();
		test_tail_lengths();
		test_output_backpressure();
		test_random_messages();

		in_valid <= 1'b0;
		while (expected_hash.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** lookup2_byte_hash: PASSED **");
		else
			$display("** lookup2_byte_hash: FAILED **");
		$finish;
	end

endmodule
